@@ rtl/chd_pkg.sv @@
package chd_pkg;

    // Sizing of the decoder.
    localparam int MAX_CODE_LEN = 16;
    localparam int SYMBOL_COUNT = 256;

    // Derived widths.
    localparam int ACC_W     = (MAX_CODE_LEN > 16) ? MAX_CODE_LEN : 16;
    localparam int LEN_W     = $clog2(MAX_CODE_LEN + 1);
    localparam int SLOT_W    = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam int SYM_IDX_W = $clog2(SYMBOL_COUNT);

    // Command queue between the front and the back; depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input word kinds.
    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_LENGTH = 2'd1;
    localparam logic [1:0] KIND_BIT    = 2'd2;

    // Configuration register indexes.
    localparam logic REG_START_SYMBOL = 1'b0;
    localparam logic REG_END_SYMBOL   = 1'b1;

    // Configuration reset values.
    localparam logic [15:0] START_SYMBOL_RESET = 16'h0000;
    localparam logic [15:0] END_SYMBOL_RESET   = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  entry_index;
        logic [7:0]  entry_symbol;
        logic [4:0]  code_length;
        logic [15:0] length_first_code;
        logic [7:0]  length_first_index;
        logic [8:0]  length_count;
        logic        coded_bit;
    } in_word_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic [4:0] symbol_length;
        logic       last;
        logic       invalid;
    } out_word_t;

    // One command for the back: a symbol table write or a result to deliver.
    typedef struct packed {
        logic       wr;
        logic [7:0] index;
        logic [7:0] data;
        logic [4:0] length;
        logic       last;
        logic       invalid;
    } cmd_t;

    // Configuration values as they stand after this cycle, plus a restart strobe.
    typedef struct packed {
        logic        restart;
        logic [15:0] start_symbol;
        logic [15:0] end_symbol;
    } cfg_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ rtl/chd_front.sv @@
module chd_front import chd_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_ctl_t cfg,
    input  logic     take,
    input  in_word_t item,
    output logic     push,
    output cmd_t     cmd
);

    logic [ACC_W-1:0]  acc_reg;
    logic [LEN_W-1:0]  bits_reg;
    logic [15:0]       decoded_reg;
    logic              finished_reg;
    logic [15:0]       first_code_reg  [MAX_CODE_LEN];
    logic [7:0]        first_index_reg [MAX_CODE_LEN];
    logic [8:0]        count_reg       [MAX_CODE_LEN];

    logic [LEN_W-1:0]  bits_inc;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] load_slot;
    logic [ACC_W-1:0]  acc_shift;
    logic [ACC_W-1:0]  first_ext;
    logic [ACC_W-1:0]  diff;
    logic              hit;
    logic              at_max;
    logic [7:0]        sidx;
    logic [15:0]       dc_plus;
    logic              is_last;
    logic              bit_active;
    logic              length_ok;

    // The slot of the code length reached by this bit is the old bit count.
    assign bits_inc   = bits_reg + 1'b1;
    assign slot       = bits_reg[SLOT_W-1:0];
    assign acc_shift  = {acc_reg[ACC_W-2:0], item.coded_bit};
    assign first_ext  = ACC_W'(first_code_reg[slot]);
    assign diff       = acc_shift - first_ext;
    assign hit        = (acc_shift >= first_ext) && (diff < ACC_W'(count_reg[slot]));
    assign at_max     = (bits_inc == LEN_W'(MAX_CODE_LEN));
    assign sidx       = first_index_reg[slot] + diff[7:0];
    assign dc_plus    = decoded_reg + 16'd1;
    assign is_last    = (dc_plus == cfg.end_symbol);
    assign bit_active = take && (item.kind == KIND_BIT) && !finished_reg;
    assign length_ok  = (item.code_length != 5'd0)
                        && ({1'b0, item.code_length} <= 6'(MAX_CODE_LEN));
    assign load_slot  = SLOT_W'(item.code_length - 5'd1);

    always_comb
    begin
        push = 1'b0;
        cmd  = '0;
        case (item.kind)
            KIND_SYMBOL:
            begin
                push      = take && ({1'b0, item.entry_index} < 9'(SYMBOL_COUNT));
                cmd.wr    = 1'b1;
                cmd.index = item.entry_index;
                cmd.data  = item.entry_symbol;
            end
            KIND_BIT:
            begin
                push        = bit_active && (hit || at_max);
                cmd.index   = sidx;
                cmd.length  = hit ? 5'(bits_inc) : 5'(MAX_CODE_LEN);
                cmd.last    = hit && is_last;
                cmd.invalid = !hit;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            bits_reg     <= '0;
            decoded_reg  <= START_SYMBOL_RESET;
            finished_reg <= 1'b0;
            for (int i = 0; i < MAX_CODE_LEN; i++)
            begin
                first_code_reg[i]  <= '0;
                first_index_reg[i] <= '0;
                count_reg[i]       <= '0;
            end
        end
        else if (cfg.restart)
        begin
            acc_reg      <= '0;
            bits_reg     <= '0;
            decoded_reg  <= cfg.start_symbol;
            finished_reg <= (cfg.start_symbol >= cfg.end_symbol);
        end
        else if (take)
        begin
            case (item.kind)
                KIND_LENGTH:
                begin
                    if (length_ok)
                    begin
                        first_code_reg[load_slot]  <= item.length_first_code;
                        first_index_reg[load_slot] <= item.length_first_index;
                        count_reg[load_slot]       <= item.length_count;
                    end
                end
                KIND_BIT:
                begin
                    if (!finished_reg)
                    begin
                        if (hit)
                        begin
                            acc_reg     <= '0;
                            bits_reg    <= '0;
                            decoded_reg <= dc_plus;
                            if (is_last)
                            begin
                                finished_reg <= 1'b1;
                            end
                        end
                        else if (at_max)
                        begin
                            acc_reg  <= '0;
                            bits_reg <= '0;
                        end
                        else
                        begin
                            acc_reg  <= acc_shift;
                            bits_reg <= bits_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ rtl/chd_queue.sv @@
module chd_queue import chd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/chd_back.sv @@
module chd_back import chd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head,
    input  logic      head_valid,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_ready,
    output out_word_t result
);

    logic [7:0] sym_mem [SYMBOL_COUNT];
    logic [7:0] sym_rd_reg;
    logic [4:0] len_reg;
    logic       last_reg;
    logic       invalid_reg;
    logic       valid_reg;

    logic       slot_free;
    logic       rd_en;

    // Table writes never wait; a result waits only for room in the output register.
    assign slot_free = !valid_reg || result_ready;
    assign pop       = head_valid && (head.wr || slot_free);
    assign rd_en     = head_valid && !head.wr && slot_free;

    always_ff @(posedge clk)
    begin
        if (pop && head.wr)
        begin
            sym_mem[head.index[SYM_IDX_W-1:0]] <= head.data;
        end
        if (rd_en)
        begin
            sym_rd_reg  <= sym_mem[head.index[SYM_IDX_W-1:0]];
            len_reg     <= head.length;
            last_reg    <= head.last;
            invalid_reg <= head.invalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign result_valid         = valid_reg;
    assign result.symbol        = invalid_reg ? 8'd0 : sym_rd_reg;
    assign result.symbol_length = len_reg;
    assign result.last          = last_reg;
    assign result.invalid       = invalid_reg;

endmodule

@@ rtl/canonical_huffman_decoder.sv @@
// Bit-serial canonical Huffman decoder. Each input word either loads one
// entry of the canonical symbol table, loads the first code, first symbol
// index and code count of one code length, or supplies the next bit of the
// coded stream, most significant bit first. The decoder accepts one word
// per clock cycle, sustained, as long as the result side keeps up: the
// front stage updates the code accumulator and compares it against the
// length table in the same cycle the word is accepted, and a four-word
// command queue decouples it from the back stage, which owns the
// single-port symbol memory and the output register. A decoded symbol (or
// an invalid-code word after MAX_CODE_LEN bits without a match) enters the
// command queue at the edge that accepts the bit completing it, and the back
// stage later registers it from the queue head onto the result port. Input
// ready drops only while the command queue is full, which happens only when
// the result side stalls. The symbol memory needs no clearing pass after
// reset; entries must be loaded before any code refers to them. Writing
// either configuration register over the APB port restarts decoding: the
// symbol counter returns to start_symbol and the accumulator is cleared.
// Configuration writes are expected only while the decoder is idle.
module canonical_huffman_decoder import chd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_ready,
    input  in_word_t    item,

    output logic        result_valid,
    input  logic        result_ready,
    output out_word_t   result,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] start_symbol_reg;
    logic [15:0] start_symbol_next;
    logic [15:0] end_symbol_reg;
    logic [15:0] end_symbol_next;
    logic        cfg_write;
    cfg_ctl_t    cfg;

    logic        take;
    logic        q_push;
    cmd_t        q_push_cmd;
    logic        q_pop;
    cmd_t        q_head;
    q_status_t   q_status;

    // The APB port completes every access without wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        start_symbol_next = start_symbol_reg;
        end_symbol_next   = end_symbol_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_START_SYMBOL: start_symbol_next = pwdata[15:0];
                REG_END_SYMBOL:   end_symbol_next   = pwdata[15:0];
                default:          start_symbol_next = start_symbol_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_symbol_reg <= START_SYMBOL_RESET;
            end_symbol_reg   <= END_SYMBOL_RESET;
        end
        else
        begin
            start_symbol_reg <= start_symbol_next;
            end_symbol_reg   <= end_symbol_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_START_SYMBOL: prdata = {16'd0, start_symbol_reg};
            REG_END_SYMBOL:   prdata = {16'd0, end_symbol_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // The front sees the register values as they will stand after this edge,
    // so a restart loads the freshly written start and end values.
    assign cfg.restart      = cfg_write;
    assign cfg.start_symbol = start_symbol_next;
    assign cfg.end_symbol   = end_symbol_next;

    // A word is taken whenever the queue has room for the command it may need.
    assign item_ready = !q_status.full;
    assign take       = item_valid && item_ready;

    chd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .take  (take),
        .item  (item),
        .push  (q_push),
        .cmd   (q_push_cmd)
    );

    chd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    chd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .head_valid   (!q_status.empty),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // An invalid-code word carries a zero symbol, the full code length and no last flag.
    a_invalid_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.invalid) |->
            (result.symbol == 8'd0) && !result.last
            && (result.symbol_length == 5'(MAX_CODE_LEN)))
        else $error("invalid-code result word is malformed");

    // The queue is never pushed while full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("command queue overflow");

    // A push without a pop leaves the queue non-empty in the next cycle.
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> !q_status.empty)
        else $error("pushed command was lost");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("command queue underflow");

endmodule
